// ===== rtl/radix2_fft_real_input_defines.svh =====
// Assertion macros shared by the FFT block, with empty stand-ins when assertions are off.
`ifndef RADIX2_FFT_REAL_INPUT_DEFINES_SVH
`define RADIX2_FFT_REAL_INPUT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define R2FFT_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("r2fft: same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted.
`define R2FFT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("r2fft: next-cycle check failed");
`else
`define R2FFT_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define R2FFT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/r2fft_pkg.sv =====
// Shared types, constants and elaboration-time twiddle functions of the FFT block.
`timescale 1ns / 1ps
package r2fft_pkg;

    localparam int VAL_W    = 27;
    localparam int BIN_W    = 10;
    localparam int CFG_W    = 4;
    localparam int P_W      = 5;
    localparam int IDX_W    = 16;
    localparam int OUT_DW   = ((2 * VAL_W + 7) / 8) * 8;

    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint unsigned ONE_Q30 = 64'd1073741824;

    typedef logic [1:0] t_rd_sel;
    localparam t_rd_sel RD_S0  = 2'd0;
    localparam t_rd_sel RD_S1  = 2'd1;
    localparam t_rd_sel RD_BIN = 2'd2;

    typedef logic [1:0] t_wr_sel;
    localparam t_wr_sel WR_LOAD = 2'd0;
    localparam t_wr_sel WR_D0   = 2'd1;
    localparam t_wr_sel WR_D1   = 2'd2;

    typedef struct packed {
        logic             bf_active;
        logic             rd_en;
        logic             rd_bank;
        t_rd_sel          rd_sel;
        logic             wr_en;
        logic             wr_bank;
        t_wr_sel          wr_sel;
        logic             cap_a;
        logic             cap_b;
        logic             calc_diff;
        logic             calc_prod;
        logic             out_load;
        logic             out_flag;
        logic [P_W-1:0]   p;
        logic [P_W-1:0]   q;
        logic [IDX_W-1:0] idx;
    } t_dp_cmd;

    // Saturate a wide signed value to the 27-bit value range.
    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (VAL_W - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi) begin
            return hi[VAL_W-1:0];
        end else if (v < lo) begin
            return lo[VAL_W-1:0];
        end
        return v[VAL_W-1:0];
    endfunction

    // Divide a series term by d * (d + 1), the factorial step of term index d.
    function automatic longint unsigned taylor_div(input longint unsigned t, input int d);
        unique case (d)
            1:       return t / 64'd2;
            2:       return t / 64'd6;
            3:       return t / 64'd12;
            4:       return t / 64'd20;
            5:       return t / 64'd30;
            6:       return t / 64'd42;
            7:       return t / 64'd56;
            8:       return t / 64'd72;
            9:       return t / 64'd90;
            10:      return t / 64'd110;
            11:      return t / 64'd132;
            12:      return t / 64'd156;
            13:      return t / 64'd182;
            14:      return t / 64'd210;
            15:      return t / 64'd240;
            16:      return t / 64'd272;
            17:      return t / 64'd306;
            18:      return t / 64'd342;
            19:      return t / 64'd380;
            20:      return t / 64'd420;
            21:      return t / 64'd462;
            22:      return t / 64'd506;
            23:      return t / 64'd552;
            24:      return t / 64'd600;
            default: return t;
        endcase
    endfunction

    // Thirteen-term Taylor series of cos (odd = 0) or sin (odd = 1), Q30 in and out.
    function automatic longint taylor(input longint unsigned x, input bit odd);
        longint unsigned x2;
        longint unsigned term;
        int              d1;
        longint          sum;
        x2   = (x * x) >> 30;
        term = odd ? x : ONE_Q30;
        sum  = longint'(term);
        for (int i = 1; i <= 12; i++) begin
            d1   = odd ? 2 * i : 2 * i - 1;
            term = taylor_div((term * x2) >> 30, d1);
            if ((i % 2) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        return sum;
    endfunction

    // Round a Q30 magnitude half up to tw-1 fraction bits and clamp it.
    function automatic longint quant(input longint v, input int tw);
        longint unsigned r;
        longint unsigned lim;
        longint          vv;
        int              sh;
        vv  = (v < 0) ? 64'sd0 : v;
        sh  = 31 - tw;
        lim = (64'd1 << (tw - 1)) - 64'd1;
        r   = (longint'(vv) + (64'd1 << (sh - 1))) >> sh;
        if (r > lim) begin
            r = lim;
        end
        return longint'(r);
    endfunction

endpackage

// ===== rtl/radix2_fft_real_input.sv =====
// Top level of the real-input radix-2 Stockham FFT with sample loads and bin reads.
// A bin read passes the bank read register, then the result register. One load request per
// cycle is taken while the result register is free; a bin read holds other requests until
// its result is loaded. The load of the last sample starts a transform of n/2 butterflies per
// stage over log2(n) stages, during which no request is taken. Reset is synchronous, active
// low, and clears the control state only; the sample banks need no clearing pass.
`timescale 1ns / 1ps
`include "radix2_fft_real_input_defines.svh"
module radix2_fft_real_input #(
    parameter int MAX_POINTS   = 1024,
    parameter int SAMPLE_BITS  = 16,
    parameter int TWIDDLE_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Size register: log2 of the point count.
    input  logic                                  i_cfg_we,
    input  logic [r2fft_pkg::CFG_W-1:0]           i_cfg_wdata,
    // Request side.
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // tdata, low bit up: sample, bin_index, zero fill to whole bytes.
    input  logic [((SAMPLE_BITS + r2fft_pkg::BIN_W + 7) / 8) * 8 - 1:0] i_s_tdata,
    // tuser: cmd (0 loads a sample, 1 reads a bin).
    input  logic                                  i_s_tuser,
    // Result side.
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // tdata, low bit up: real_part, imag_part, zero fill to whole bytes.
    output logic [r2fft_pkg::OUT_DW-1:0]          o_m_tdata,
    // tuser: result_valid.
    output logic                                  o_m_tuser
);
    import r2fft_pkg::*;

    // The controller walks requests and the butterfly schedule; the datapath holds
    // the two complex sample banks. Samples always go to the bank that does not
    // hold the current spectrum, so later loads never disturb bin reads. A
    // transform ping-pongs between the banks one stage at a time, and when the
    // stage count is even the spectrum simply ends up in the load bank, which
    // then swaps roles with the other bank instead of being copied.
    //
    // A butterfly runs on the shared unit in these steps: two bank reads, the
    // capture of the second operand, the sum and difference, four products (the
    // sum is written here), and the write of the rounded product (plain difference for twiddle one).

    t_dp_cmd w_cmd;

    r2fft_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tuser   (o_m_tuser),
        .o_cmd       (w_cmd)
    );

    r2fft_dp #(
        .MAX_POINTS   (MAX_POINTS),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .TWIDDLE_BITS (TWIDDLE_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_cmd     (w_cmd),
        .i_sample  (i_s_tdata[SAMPLE_BITS-1:0]),
        .i_bin     (i_s_tdata[SAMPLE_BITS+BIN_W-1:SAMPLE_BITS]),
        .o_m_tdata (o_m_tdata)
    );

    // No request may be taken while a transform runs.
    `R2FFT_ASSERT_IMPLY(a_busy_blocks, i_clk, i_rst_n, w_cmd.bf_active, !o_s_tready)
    // A bin read request leaves the result register empty while the bank is read.
    `R2FFT_ASSERT_NEXT(a_read_gap, i_clk, i_rst_n,
        i_s_tvalid && o_s_tready && i_s_tuser, !o_m_tvalid)
    // The result register is only loaded when it is empty.
    `R2FFT_ASSERT_IMPLY(a_load_empty, i_clk, i_rst_n, w_cmd.out_load, !o_m_tvalid)
    // Without a finished transform the parts read as zero.
    `R2FFT_ASSERT_IMPLY(a_zero_parts, i_clk, i_rst_n,
        o_m_tvalid && !o_m_tuser, o_m_tdata == '0)

endmodule

// ===== rtl/r2fft_ctrl.sv =====
// Controller state machine: request handshakes, load position, stage and butterfly sequencing.
`timescale 1ns / 1ps
module r2fft_ctrl #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [r2fft_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic                         i_s_tuser,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic                         o_m_tuser,
    output r2fft_pkg::t_dp_cmd           o_cmd
);
    import r2fft_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RDW  = 3'd1;
    localparam logic [2:0] S_RD0  = 3'd2;
    localparam logic [2:0] S_RD1  = 3'd3;
    localparam logic [2:0] S_CAP  = 3'd4;
    localparam logic [2:0] S_DIFF = 3'd5;
    localparam logic [2:0] S_PROD = 3'd6;
    localparam logic [2:0] S_WR1  = 3'd7;

    logic [2:0]       r_state, n_state;
    logic [CFG_W-1:0] r_log2, n_log2;
    logic [AW:0]      r_pos, n_pos;
    logic             r_have, n_have;
    logic             r_spec, n_spec;
    logic             r_src, n_src;
    logic [P_W-1:0]   r_q, n_q;
    logic [AW-1:0]    r_i, n_i;
    logic             r_out_v, n_out_v;
    logic             r_out_flag, n_out_flag;

    logic [P_W-1:0] w_p;
    logic [AW:0]    w_n;
    logic [AW-1:0]  w_half_m1;
    logic [AW:0]    w_widx;
    logic [AW:0]    w_pos_next;
    logic           w_accept;

    // Sizes beyond the buffer clamp to the largest one, zero acts as one.
    always_comb begin
        if (r_log2 == '0) begin
            w_p = P_W'(1);
        end else if (P_W'(r_log2) > P_W'(AW)) begin
            w_p = P_W'(AW);
        end else begin
            w_p = P_W'(r_log2);
        end
    end

    assign w_n        = (AW+1)'(1) << w_p;
    assign w_half_m1  = AW'((w_n - (AW+1)'(1)) >> 1);
    assign w_widx     = (r_pos < w_n) ? r_pos : '0;
    assign w_pos_next = w_widx + (AW+1)'(1);

    assign o_s_tready = i_rst_n && (r_state == S_IDLE) && (!r_out_v || i_m_tready);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_v;
    assign o_m_tuser  = r_out_flag;

    always_comb begin
        n_state    = r_state;
        n_log2     = r_log2;
        n_pos      = r_pos;
        n_have     = r_have;
        n_spec     = r_spec;
        n_src      = r_src;
        n_q        = r_q;
        n_i        = r_i;
        n_out_v    = r_out_v;
        n_out_flag = r_out_flag;

        o_cmd           = '0;
        o_cmd.p         = w_p;
        o_cmd.q         = r_q;
        o_cmd.idx       = IDX_W'(r_i);
        o_cmd.bf_active = (r_state != S_IDLE) && (r_state != S_RDW);

        if (r_out_v && i_m_tready) begin
            n_out_v = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cfg_we) begin
                    n_log2 = i_cfg_wdata;
                    n_pos  = '0;
                    n_have = 1'b0;
                end
                if (w_accept && !i_s_tuser) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_bank = ~r_spec;
                    o_cmd.wr_sel  = WR_LOAD;
                    o_cmd.idx     = IDX_W'(w_widx);
                    if (w_pos_next == w_n) begin
                        n_pos   = '0;
                        n_state = S_RD0;
                        n_q     = P_W'(1);
                        n_i     = '0;
                        n_src   = ~r_spec;
                    end else begin
                        n_pos = w_pos_next;
                    end
                end else if (w_accept) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_bank = r_spec;
                    o_cmd.rd_sel  = RD_BIN;
                    n_state       = S_RDW;
                end
            end
            S_RDW: begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_flag = r_have;
                n_out_v        = 1'b1;
                n_out_flag     = r_have;
                n_state        = S_IDLE;
            end
            S_RD0: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_bank = r_src;
                o_cmd.rd_sel  = RD_S0;
                n_state       = S_RD1;
            end
            S_RD1: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_bank = r_src;
                o_cmd.rd_sel  = RD_S1;
                o_cmd.cap_a   = 1'b1;
                n_state       = S_CAP;
            end
            S_CAP: begin
                o_cmd.cap_b = 1'b1;
                n_state     = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.calc_diff = 1'b1;
                n_state         = S_PROD;
            end
            S_PROD: begin
                o_cmd.calc_prod = 1'b1;
                o_cmd.wr_en     = 1'b1;
                o_cmd.wr_bank   = ~r_src;
                o_cmd.wr_sel    = WR_D0;
                n_state         = S_WR1;
            end
            S_WR1: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_bank = ~r_src;
                o_cmd.wr_sel  = WR_D1;
                n_state       = S_RD0;
                if (r_i == w_half_m1) begin
                    n_i   = '0;
                    n_src = ~r_src;
                    if (r_q == w_p) begin
                        // The last stage wrote the spectrum into the other bank.
                        n_spec  = ~r_src;
                        n_have  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_q = r_q + P_W'(1);
                    end
                end else begin
                    n_i = r_i + AW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_log2     <= CFG_W'(10);
            r_pos      <= '0;
            r_have     <= 1'b0;
            r_spec     <= 1'b0;
            r_src      <= 1'b0;
            r_q        <= '0;
            r_i        <= '0;
            r_out_v    <= 1'b0;
            r_out_flag <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_log2     <= n_log2;
            r_pos      <= n_pos;
            r_have     <= n_have;
            r_spec     <= n_spec;
            r_src      <= n_src;
            r_q        <= n_q;
            r_i        <= n_i;
            r_out_v    <= n_out_v;
            r_out_flag <= n_out_flag;
        end
    end

endmodule

// ===== rtl/r2fft_dp.sv =====
// Datapath: two complex sample banks, twiddle table, butterfly unit and result register.
`timescale 1ns / 1ps
module r2fft_dp #(
    parameter int MAX_POINTS   = 1024,
    parameter int SAMPLE_BITS  = 16,
    parameter int TWIDDLE_BITS = 16
) (
    input  logic                          i_clk,
    input  r2fft_pkg::t_dp_cmd            i_cmd,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic [r2fft_pkg::BIN_W-1:0]   i_bin,
    output logic [r2fft_pkg::OUT_DW-1:0]  o_m_tdata
);
    import r2fft_pkg::*;

    localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int TAW  = (AW > 1) ? AW - 1 : 1;
    localparam int TDEP = (MAX_POINTS / 2 > 0) ? MAX_POINTS / 2 : 1;
    localparam int DW   = 2 * VAL_W;
    localparam int PRW  = VAL_W + 1 + TWIDDLE_BITS;

    // Twiddle table, fixed at elaboration.
    logic signed [TWIDDLE_BITS-1:0] w_rom_re [TDEP];
    logic signed [TWIDDLE_BITS-1:0] w_rom_im [TDEP];

    for (genvar m = 0; m < TDEP; m++) begin : g_rom
        localparam int QM = (m <= MAX_POINTS / 4) ? m : MAX_POINTS / 2 - m;
        localparam longint unsigned ANG = (PI_Q30 * 64'd2 * QM) / MAX_POINTS;
        localparam longint CV = quant(taylor(ANG, 1'b0), TWIDDLE_BITS);
        localparam longint SV = quant(taylor(ANG, 1'b1), TWIDDLE_BITS);
        localparam longint RE = (m > MAX_POINTS / 4) ? -CV : CV;
        localparam longint IM = -SV;
        assign w_rom_re[m] = TWIDDLE_BITS'(RE);
        assign w_rom_im[m] = TWIDDLE_BITS'(IM);
    end

    logic [DW-1:0] r_bank0 [MAX_POINTS];
    logic [DW-1:0] r_bank1 [MAX_POINTS];
    logic [DW-1:0] r_q0, r_q1;
    logic          r_rd_bank;

    logic [AW-1:0]  w_idx, w_half, w_span, w_smask, w_hi, w_j;
    logic [AW-1:0]  w_s1, w_d0, w_d1, w_nmask, w_bin, w_raddr, w_waddr, w_tfull;
    logic [TAW-1:0] w_t;
    logic [IDX_W-1:0] w_bin_ext;
    logic [DW-1:0]  w_rdat, w_wdat;

    logic signed [VAL_W-1:0]        r_a_re, r_a_im, r_b_re, r_b_im;
    logic signed [VAL_W-1:0]        r_sum_re, r_sum_im;
    logic signed [VAL_W:0]          r_dr, r_di;
    logic signed [TWIDDLE_BITS-1:0] r_wr, r_wi;
    logic                           r_triv;
    logic signed [PRW-1:0]          r_p_rr, r_p_ii, r_p_ri, r_p_ir;
    logic signed [63:0]             w_acc_re, w_acc_im, w_rnd_re, w_rnd_im;
    logic signed [VAL_W-1:0]        w_d1_re, w_d1_im;
    logic signed [VAL_W-1:0]        r_out_re, r_out_im;

    assign w_idx   = i_cmd.idx[AW-1:0];
    assign w_half  = AW'(1) << (i_cmd.p - P_W'(1));
    assign w_span  = AW'(1) << (i_cmd.q - P_W'(1));
    assign w_smask = w_span - AW'(1);
    assign w_hi    = w_idx & ~w_smask;
    assign w_j     = w_idx & w_smask;
    assign w_s1    = w_idx | w_half;
    assign w_d0    = (w_hi << 1) | w_j;
    assign w_d1    = w_d0 | w_span;
    assign w_tfull = w_hi << (P_W'(AW) - i_cmd.p);
    assign w_t     = w_tfull[TAW-1:0] & TAW'(MAX_POINTS / 2 - 1);

    assign w_nmask   = AW'(((AW+1)'(1) << i_cmd.p) - (AW+1)'(1));
    assign w_bin_ext = IDX_W'(i_bin);
    assign w_bin     = w_bin_ext[AW-1:0] & w_nmask;

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_S1:   w_raddr = w_s1;
            RD_BIN:  w_raddr = w_bin;
            default: w_raddr = w_idx;
        endcase
    end

    // Butterfly difference output: rounded complex product, or the plain
    // difference when the twiddle is one.
    assign w_acc_re = 64'(r_p_rr) - 64'(r_p_ii);
    assign w_acc_im = 64'(r_p_ri) + 64'(r_p_ir);
    assign w_rnd_re = (w_acc_re + (64'sd1 <<< (TWIDDLE_BITS - 2))) >>> (TWIDDLE_BITS - 1);
    assign w_rnd_im = (w_acc_im + (64'sd1 <<< (TWIDDLE_BITS - 2))) >>> (TWIDDLE_BITS - 1);
    assign w_d1_re  = r_triv ? sat_val(64'(r_dr)) : sat_val(w_rnd_re);
    assign w_d1_im  = r_triv ? sat_val(64'(r_di)) : sat_val(w_rnd_im);

    always_comb begin
        unique case (i_cmd.wr_sel)
            WR_D0: begin
                w_waddr = w_d0;
                w_wdat  = {r_sum_im, r_sum_re};
            end
            WR_D1: begin
                w_waddr = w_d1;
                w_wdat  = {w_d1_im, w_d1_re};
            end
            default: begin
                w_waddr = w_idx;
                w_wdat  = {{VAL_W{1'b0}}, VAL_W'(i_sample)};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && !i_cmd.wr_bank) begin
            r_bank0[w_waddr] <= w_wdat;
        end
        if (i_cmd.rd_en && !i_cmd.rd_bank) begin
            r_q0 <= r_bank0[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && i_cmd.wr_bank) begin
            r_bank1[w_waddr] <= w_wdat;
        end
        if (i_cmd.rd_en && i_cmd.rd_bank) begin
            r_q1 <= r_bank1[w_raddr];
        end
    end

    assign w_rdat = r_rd_bank ? r_q1 : r_q0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_bank <= i_cmd.rd_bank;
        end
        r_wr   <= w_rom_re[w_t];
        r_wi   <= w_rom_im[w_t];
        r_triv <= (w_t == '0);
        if (i_cmd.cap_a) begin
            r_a_re <= w_rdat[VAL_W-1:0];
            r_a_im <= w_rdat[DW-1:VAL_W];
        end
        if (i_cmd.cap_b) begin
            r_b_re <= w_rdat[VAL_W-1:0];
            r_b_im <= w_rdat[DW-1:VAL_W];
        end
        if (i_cmd.calc_diff) begin
            r_sum_re <= sat_val(64'(r_a_re) + 64'(r_b_re));
            r_sum_im <= sat_val(64'(r_a_im) + 64'(r_b_im));
            r_dr     <= (VAL_W+1)'(r_a_re) - (VAL_W+1)'(r_b_re);
            r_di     <= (VAL_W+1)'(r_a_im) - (VAL_W+1)'(r_b_im);
        end
        if (i_cmd.calc_prod) begin
            r_p_rr <= PRW'(r_dr * r_wr);
            r_p_ii <= PRW'(r_di * r_wi);
            r_p_ri <= PRW'(r_dr * r_wi);
            r_p_ir <= PRW'(r_di * r_wr);
        end
        if (i_cmd.out_load) begin
            r_out_re <= i_cmd.out_flag ? w_rdat[VAL_W-1:0] : '0;
            r_out_im <= i_cmd.out_flag ? w_rdat[DW-1:VAL_W] : '0;
        end
    end

    assign o_m_tdata = {{(OUT_DW - DW){1'b0}}, r_out_im, r_out_re};

endmodule

// ===== bench/radix2_fft_real_input_tb.sv =====
// Self-checking bench for the real-input radix-2 FFT: sample loads, transforms and bin reads.
`timescale 1ns / 1ps
module radix2_fft_real_input_tb;

    // Request kinds carried in tuser.
    localparam bit CMD_LOAD = 1'b0;
    localparam bit CMD_READ = 1'b1;

    // The longest transform (1024 points) runs with no request taken, so the
    // watchdog gives idle stretches well beyond its length.
    localparam int IDLE_LIMIT   = 200000;
    localparam int ITEM_TARGET  = 1500;

    typedef struct packed {
        logic signed [26:0] re;
        logic signed [26:0] im;
        logic               flag;
    } t_bin_value;

    typedef enum logic {ROW_CFG, ROW_REQ} t_row_kind;

    typedef struct {
        t_row_kind          kind;
        bit                 cmd;
        logic signed [15:0] sample;
        logic [9:0]         bin;
        bit                 typed;
        t_bin_value         want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [3:0]  i_cfg_wdata = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    // tdata, low bit up: sample, bin_index, zero fill.
    logic [31:0] i_s_tdata = '0;
    // tuser: cmd.
    logic        i_s_tuser = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    // tdata, low bit up: real_part, imag_part, zero fill.
    logic [55:0] o_m_tdata;
    // tuser: result_valid.
    logic        o_m_tuser;

    always #1 i_clk = ~i_clk;

    radix2_fft_real_input dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    // ------------------------------------------------------------------
    // Spectrum predictor. Bank 0 is the load (ping) bank, bank 1 holds the
    // finished spectrum (pong). The twiddle table covers half a turn at 1024
    // points; smaller sizes step through it with a stride.
    // ------------------------------------------------------------------
    longint      bank_re[2][1024];
    longint      bank_im[2][1024];
    longint      tw_re[512];
    longint      tw_im[512];
    logic [3:0]  size_reg = 4'd10;
    int unsigned fill_pos = 0;
    bit          have_spectrum = 1'b0;

    t_bin_value  pending_bins[$];
    int          errors = 0;
    int          items_sent = 0;

    // Cosine (odd = 0) or sine (odd = 1) of a Q30 angle by a thirteen-term series.
    function automatic longint series_q30(input longint unsigned x, input bit odd);
        longint unsigned x2;
        longint unsigned term;
        longint unsigned d;
        longint          acc;
        x2   = (x * x) >> 30;
        term = odd ? x : 64'd1073741824;
        acc  = longint'(term);
        for (int i = 1; i <= 12; i++) begin
            d    = odd ? 64'(2 * i) : 64'(2 * i - 1);
            term = ((term * x2) >> 30) / (d * (d + 64'd1));
            if (i % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        return acc;
    endfunction

    // Q30 magnitude to Q15, rounded half up and clamped below one.
    function automatic longint to_q15(input longint v);
        longint r;
        if (v < 0) begin
            v = 0;
        end
        r = (v + 64'sd16384) >>> 15;
        return (r > 32767) ? 64'sd32767 : r;
    endfunction

    function automatic longint clip27(input longint v);
        if (v > 64'sd67108863) begin
            return 64'sd67108863;
        end else if (v < -64'sd67108864) begin
            return -64'sd67108864;
        end
        return v;
    endfunction

    function automatic longint round_q15(input longint v);
        return (v + 64'sd16384) >>> 15;
    endfunction

    function automatic int fft_order();
        int l;
        l = size_reg;
        if (l < 1) begin
            l = 1;
        end
        if (l > 10) begin
            l = 10;
        end
        return l;
    endfunction

    task automatic fill_twiddles();
        longint unsigned ang;
        int              q;
        longint          c;
        longint          s;
        for (int m = 0; m < 512; m++) begin
            q   = (m <= 256) ? m : 512 - m;
            ang = (64'd3373259426 * 2 * longint'(q)) / 1024;
            c   = to_q15(series_q30(ang, 1'b0));
            s   = to_q15(series_q30(ang, 1'b1));
            tw_re[m] = (m > 256) ? -c : c;
            tw_im[m] = -s;
        end
    endtask

    // All stages of the Stockham transform over the loaded frame.
    task automatic run_spectrum(input int p);
        int     n;
        int     half;
        int     stride;
        int     src;
        int     dst;
        int     span;
        int     s0;
        int     s1;
        int     d0;
        int     d1;
        int     t;
        longint xr;
        longint xi;
        n      = 1 << p;
        half   = n >> 1;
        stride = 1024 >> p;
        for (int q = 1; q <= p; q++) begin
            src  = (q % 2 == 1) ? 0 : 1;
            dst  = 1 - src;
            span = 1 << (q - 1);
            for (int k = 0; k < (1 << (p - q)); k++) begin
                for (int j = 0; j < span; j++) begin
                    s0 = k * span + j;
                    s1 = s0 + half;
                    d0 = k * 2 * span + j;
                    d1 = d0 + span;
                    t  = (k * span * stride) & 511;
                    xr = bank_re[src][s0] - bank_re[src][s1];
                    xi = bank_im[src][s0] - bank_im[src][s1];
                    bank_re[dst][d0] = clip27(bank_re[src][s0] + bank_re[src][s1]);
                    bank_im[dst][d0] = clip27(bank_im[src][s0] + bank_im[src][s1]);
                    // The zero-angle twiddle is skipped: the difference passes unscaled.
                    if (t == 0) begin
                        bank_re[dst][d1] = clip27(xr);
                        bank_im[dst][d1] = clip27(xi);
                    end else begin
                        bank_re[dst][d1] = clip27(round_q15(xr * tw_re[t] - xi * tw_im[t]));
                        bank_im[dst][d1] = clip27(round_q15(xr * tw_im[t] + xi * tw_re[t]));
                    end
                end
            end
        end
        // With an even stage count the result ends in the load bank.
        if (p % 2 == 0) begin
            for (int i = 0; i < n; i++) begin
                bank_re[1][i] = bank_re[0][i];
                bank_im[1][i] = bank_im[0][i];
            end
        end
    endtask

    task automatic load_sample(input logic signed [15:0] smp);
        int          p;
        int unsigned n;
        int unsigned slot;
        p    = fft_order();
        n    = 1 << p;
        slot = (fill_pos < n) ? fill_pos : 0;
        bank_re[0][slot] = smp;
        bank_im[0][slot] = 0;
        fill_pos = slot + 1;
        if (fill_pos >= n) begin
            run_spectrum(p);
            have_spectrum = 1'b1;
            fill_pos      = 0;
        end
    endtask

    function automatic t_bin_value bin_lookup(input logic [9:0] bin);
        t_bin_value  v;
        int unsigned b;
        v = '0;
        if (have_spectrum) begin
            b      = bin & ((1 << fft_order()) - 1);
            v.re   = bank_re[1][b][26:0];
            v.im   = bank_im[1][b][26:0];
            v.flag = 1'b1;
        end
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Request side: bursts of random length separated by random gaps.
    // ------------------------------------------------------------------
    int burst_left = 0;

    task automatic issue(input bit cmd, input logic signed [15:0] smp, input logic [9:0] bin,
                         input bit typed, input t_bin_value want);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {6'b0, bin, smp};
        do @(posedge i_clk); while (!o_s_tready);
        burst_left--;
        items_sent++;
        if (cmd == CMD_LOAD) begin
            load_sample(smp);
        end else begin
            pending_bins.push_back(typed ? want : bin_lookup(bin));
        end
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_bins.size() != 0) @(posedge i_clk);
    endtask

    // The size register is written only once the block is idle; a transform
    // started by the last load may still be running, so its full length passes.
    task automatic write_size(input logic [3:0] v);
        int p;
        drain_results();
        p = fft_order();
        repeat (3 * (1 << p) * p + 16) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        size_reg      = v;
        fill_pos      = 0;
        have_spectrum = 1'b0;
    endtask

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 5))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'($urandom_range(0, 31)) - 16'sd16;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_read();
        issue(CMD_READ, 16'($urandom), 10'($urandom), 1'b0, '0);
    endtask

    // One frame of loads with reads of the previous spectrum mixed in, then reads.
    task automatic random_frame(input int n, input bit broken);
        int count;
        count = broken ? $urandom_range(1, n - 1) : n;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 5) == 0) begin
                random_read();
            end
            issue(CMD_LOAD, pick_sample(), 10'($urandom), 1'b0, '0);
        end
        repeat ($urandom_range(4, 12)) random_read();
    endtask

    // ------------------------------------------------------------------
    // Result side: the ready pattern switches among three modes, picked at random.
    // ------------------------------------------------------------------
    int          stall_mode = 0;
    int unsigned rx_cycle = 0;
    int          idle_cycles = 0;

    always @(posedge i_clk) begin
        t_bin_value want;
        t_bin_value got;
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 100 == 0) begin
            stall_mode <= $urandom_range(0, 2);
        end
        case (stall_mode)
            0:       i_m_tready <= 1'b1;
            1:       i_m_tready <= ($urandom_range(0, 3) != 0);
            default: i_m_tready <= ($urandom_range(0, 3) == 0);
        endcase
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.re   = o_m_tdata[26:0];
            got.im   = o_m_tdata[53:27];
            got.flag = o_m_tuser;
            if (pending_bins.size() == 0) begin
                $display("%0t: unexpected bin result re=%0d im=%0d flag=%0b",
                         $time, got.re, got.im, got.flag);
                errors++;
            end else begin
                want = pending_bins.pop_front();
                if (got.re !== want.re) begin
                    $display("%0t: real part expected %0d actual %0d", $time, want.re, got.re);
                    errors++;
                end
                if (got.im !== want.im) begin
                    $display("%0t: imag part expected %0d actual %0d", $time, want.im, got.im);
                    errors++;
                end
                if (got.flag !== want.flag) begin
                    $display("%0t: result_valid expected %0b actual %0b",
                             $time, want.flag, got.flag);
                    errors++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither side moves a request.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------
    t_row directed[$];

    task automatic add_row(input t_row_kind kind, input bit cmd, input int smp, input int bin,
                           input bit typed, input int re, input int im, input bit flag);
        t_row r;
        r.kind      = kind;
        r.cmd       = cmd;
        r.sample    = 16'(smp);
        r.bin       = 10'(bin);
        r.typed     = typed;
        r.want.re   = 27'(re);
        r.want.im   = 27'(im);
        r.want.flag = flag;
        directed.push_back(r);
    endtask

    initial begin
        int l;
        fill_twiddles();

        // Read before any transform at the reset size, then the two-point size,
        // where each bin is plain sum and difference.
        add_row(ROW_REQ, CMD_READ, 0, 0, 1, 0, 0, 0);
        add_row(ROW_CFG, 0, 0, 1, 0, 0, 0, 0);
        add_row(ROW_REQ, CMD_READ, 0, 1023, 1, 0, 0, 0);
        add_row(ROW_REQ, CMD_LOAD, 32767, 0, 0, 0, 0, 0);
        add_row(ROW_REQ, CMD_LOAD, -32768, 1023, 0, 0, 0, 0);
        add_row(ROW_REQ, CMD_READ, 0, 0, 1, -1, 0, 1);
        add_row(ROW_REQ, CMD_READ, 0, 1, 1, 65535, 0, 1);
        // Bin index wraps modulo the point count.
        add_row(ROW_REQ, CMD_READ, -1, 1023, 1, 65535, 0, 1);
        add_row(ROW_REQ, CMD_LOAD, 0, 0, 0, 0, 0, 0);
        add_row(ROW_REQ, CMD_LOAD, -1, 0, 0, 0, 0, 0);
        add_row(ROW_REQ, CMD_READ, 0, 0, 1, -1, 0, 1);
        add_row(ROW_REQ, CMD_READ, 0, 1, 1, 1, 0, 1);
        // Size zero acts as two points; the write drops the old spectrum.
        add_row(ROW_CFG, 0, 0, 0, 0, 0, 0, 0);
        add_row(ROW_REQ, CMD_READ, 0, 1, 1, 0, 0, 0);
        add_row(ROW_REQ, CMD_LOAD, -32768, 0, 0, 0, 0, 0);
        add_row(ROW_REQ, CMD_LOAD, -32768, 0, 0, 0, 0, 0);
        add_row(ROW_REQ, CMD_READ, 0, 0, 1, -65536, 0, 1);
        add_row(ROW_REQ, CMD_READ, 0, 1, 1, 0, 0, 1);
        // Four points reach the quarter-turn twiddle.
        add_row(ROW_CFG, 0, 0, 2, 0, 0, 0, 0);
        add_row(ROW_REQ, CMD_LOAD, 32767, 0, 0, 0, 0, 0);
        add_row(ROW_REQ, CMD_LOAD, -32768, 0, 0, 0, 0, 0);
        add_row(ROW_REQ, CMD_LOAD, 1, 0, 0, 0, 0, 0);
        add_row(ROW_REQ, CMD_LOAD, 12345, 0, 0, 0, 0, 0);
        for (int b = 0; b < 4; b++) begin
            add_row(ROW_REQ, CMD_READ, 0, b, 0, 0, 0, 0);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            if (directed[i].kind == ROW_CFG) begin
                write_size(directed[i].bin[3:0]);
            end else begin
                issue(directed[i].cmd, directed[i].sample, directed[i].bin,
                      directed[i].typed, directed[i].want);
            end
        end

        // One full-size frame; a size above the maximum acts as the maximum.
        write_size(4'd15);
        random_frame(1024, 1'b0);

        // Mostly small sizes with whole frames, some broken frames and stray reads.
        while (items_sent < ITEM_TARGET) begin
            l = ($urandom_range(0, 7) == 0) ? 6 : $urandom_range(0, 5);
            write_size(4'(l));
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 4)) random_read();
            end
            repeat ($urandom_range(1, 4)) begin
                random_frame((l < 1) ? 2 : (1 << l), $urandom_range(0, 7) == 0);
                // Sometimes let every outstanding read come back before going on.
                if ($urandom_range(0, 3) == 0) begin
                    drain_results();
                end
            end
        end

        // The maximum size written as such, with a partial frame and early reads.
        write_size(4'd10);
        repeat (20) issue(CMD_LOAD, pick_sample(), 10'($urandom), 1'b0, '0);
        repeat (8) random_read();

        drain_results();
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
